[design/gne_pkg.sv]
// Shared constants, types and tables for the gauge needle endpoint pipeline.
package gne_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int TRIG_STAGES = 16;
  localparam int FRAC_BITS   = 30;
  localparam int QW          = FRAC_BITS + 1;  // Q1.30 span fraction
  localparam int CW          = 34;             // CORDIC datapath width, Q30 signed
  localparam int ATAN_LEN    = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int PIX_W       = 12;             // signed pixel arithmetic width

  localparam logic [QW-1:0] HALF_PI_Q30    = 31'h6487_ED51;
  localparam logic [CW-1:0] QUARTER_PI_Q30 = 34'h0_3243_F6A9;
  localparam logic [CW-1:0] INV_GAIN_Q30   = 34'h0_26DD_3B6A;

  localparam logic signed [PIX_W-1:0] PIVOT_X = 12'sd120;
  localparam logic signed [PIX_W-1:0] PIVOT_Y = 12'sd195;

  localparam logic [CW-1:0] ATAN_Q30 [ATAN_LEN] = '{
    34'h0_3243_F6A8, 34'h0_1DAC_6705, 34'h0_0FAD_BAFC, 34'h0_07F5_6EA6,
    34'h0_03FE_AB76, 34'h0_01FF_D55B, 34'h0_00FF_FAAA, 34'h0_007F_FF55,
    34'h0_003F_FFEA, 34'h0_001F_FFFD, 34'h0_000F_FFFF, 34'h0_0007_FFFF,
    34'h0_0003_FFFF, 34'h0_0001_FFFF, 34'h0_0000_FFFF, 34'h0_0000_7FFF,
    34'h0_0000_3FFF, 34'h0_0000_1FFF, 34'h0_0000_0FFF, 34'h0_0000_07FF,
    34'h0_0000_03FF, 34'h0_0000_01FF, 34'h0_0000_00FF, 34'h0_0000_007F
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_MIN  = 2'd0,
    REG_SCALE_MAX  = 2'd1,
    REG_QUANT_STEP = 2'd2
  } cfg_reg_t;

endpackage

[design/gne_div_cell.sv]
// One restoring division step: shifts a dividend bit into the remainder.
module gne_div_cell #(
  parameter int RW = 32,
  parameter int WW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  logic [RW-1:0] rem_i,
  input  logic [WW-1:0] word_i,
  input  logic [RW-1:0] den_i,
  output logic          vld_o,
  output logic [RW-1:0] rem_o,
  output logic [WW-1:0] word_o
);

  logic          vld_r;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [WW-1:0] word_r, word_nxt;
  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;

  always_comb begin
    trial    = {rem_i, word_i[WW-1]};
    diff     = trial - {1'b0, den_i};
    ge       = (trial >= {1'b0, den_i});
    rem_nxt  = ge ? diff[RW-1:0] : trial[RW-1:0];
    // shift the quotient bit in behind the dividend bits still to come
    word_nxt = {word_i[WW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    rem_r  <= rem_nxt;
    word_r <= word_nxt;
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign word_o = word_r;

endmodule

[design/gne_cordic_cell.sv]
// One CORDIC rotation step in Q30 with a fixed arctangent constant.
module gne_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic signed [gne_pkg::CW-1:0] x_i,
  input  logic signed [gne_pkg::CW-1:0] y_i,
  input  logic signed [gne_pkg::CW-1:0] z_i,
  output logic                          vld_o,
  output logic signed [gne_pkg::CW-1:0] x_o,
  output logic signed [gne_pkg::CW-1:0] y_o,
  output logic signed [gne_pkg::CW-1:0] z_o
);

  localparam logic signed [gne_pkg::CW-1:0] ATAN = gne_pkg::ATAN_Q30[IDX];

  logic                          vld_r;
  logic signed [gne_pkg::CW-1:0] x_r, x_nxt;
  logic signed [gne_pkg::CW-1:0] y_r, y_nxt;
  logic signed [gne_pkg::CW-1:0] z_r, z_nxt;
  logic signed [gne_pkg::CW-1:0] dx, dy;

  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    if (!z_i[gne_pkg::CW-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign vld_o = vld_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

[design/gauge_needle_endpoints.sv]
// Top level: reading to needle tip and tail pixels, fully pipelined.
//
//  channel  ports                                        handshake
//  in       start, busy, in_reading                      start & !busy
//  out      out_valid, out_tip_x/y, out_tail_x/y         one-cycle strobe
//  cfg      cfg_we, cfg_index, cfg_wdata                 write on cfg_we
//
// One item is accepted every cycle; busy stays low.
// Each item passes through the quantize divider row, the 31-cell fraction
// divider row and the CORDIC row.
// Reset clears the valid chain and loads the register reset values.
// The receiver cannot stall; each result shows for exactly one cycle.
module gauge_needle_endpoints #(
  parameter int VALUE_WIDTH = gne_pkg::VALUE_WIDTH,
  parameter int TRIG_STAGES = gne_pkg::TRIG_STAGES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] in_reading,
  output logic                          out_valid,
  output logic [7:0]                    out_tip_x,
  output logic [7:0]                    out_tip_y,
  output logic [7:0]                    out_tail_x,
  output logic [7:0]                    out_tail_y,
  input  logic                          cfg_we,
  input  logic [gne_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_WIDTH-1:0]        cfg_wdata
);

  localparam int W   = VALUE_WIDTH;
  localparam int QW  = gne_pkg::QW;
  localparam int CW  = gne_pkg::CW;
  localparam int PW  = gne_pkg::PIX_W;
  localparam int LAT = W + QW + TRIG_STAGES + 5;

  // configuration
  logic signed [W-1:0] scale_min_r, scale_max_r, quant_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_min_r  <= '0;
      scale_max_r  <= W'(32'sd6553600);
      quant_step_r <= '0;
    end else if (cfg_we) begin
      unique case (gne_pkg::cfg_reg_t'(cfg_index))
        gne_pkg::REG_SCALE_MIN:  scale_min_r  <= cfg_wdata;
        gne_pkg::REG_SCALE_MAX:  scale_max_r  <= cfg_wdata;
        gne_pkg::REG_QUANT_STEP: quant_step_r <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  logic          step_pos, span_pos;
  logic [W-1:0]  span;
  assign step_pos = (quant_step_r > 0);
  assign span_pos = (scale_max_r > scale_min_r);
  assign span     = scale_max_r - scale_min_r;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // quantize: remainder of |reading| by the step
  logic         q_vld  [W+1];
  logic [W-1:0] q_rem  [W+1];
  logic [W-1:0] q_word [W+1];
  logic signed [W-1:0] qv_r [W];

  assign q_vld[0]  = accept;
  assign q_rem[0]  = '0;
  assign q_word[0] = in_reading[W-1] ? (~in_reading + 1'b1) : in_reading;

  for (genvar k = 0; k < W; k++) begin : g_qcell
    gne_div_cell #(.RW(W), .WW(W)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .vld_i(q_vld[k]), .rem_i(q_rem[k]), .word_i(q_word[k]), .den_i(quant_step_r),
      .vld_o(q_vld[k+1]), .rem_o(q_rem[k+1]), .word_o(q_word[k+1])
    );
  end

  always_ff @(posedge clk) begin
    qv_r[0] <= in_reading;
    for (int k = 1; k < W; k++) begin
      qv_r[k] <= qv_r[k-1];
    end
  end

  // rebuild the quantized value: sign * (|v| - rem), or pass the reading on when the step is not positive
  logic                qr_vld_r;
  logic signed [W-1:0] qres_r, qres_nxt;
  logic [W-1:0]        qmag, qdiff;
  logic signed [W-1:0] qlast;

  always_comb begin
    qlast    = qv_r[W-1];
    qmag     = qlast[W-1] ? (~qlast + 1'b1) : qlast;
    qdiff    = qmag - q_rem[W];
    qres_nxt = qlast;
    if (step_pos) begin
      qres_nxt = qlast[W-1] ? (~qdiff + 1'b1) : qdiff;
    end
  end

  // clamp and offset from the low end
  logic         am_vld_r;
  logic [W-1:0] amount_r, amount_nxt;
  logic signed [W-1:0] clamped;

  always_comb begin
    clamped = qres_r;
    if (qres_r < scale_min_r) clamped = scale_min_r;
    if (qres_r > scale_max_r) clamped = scale_max_r;
    amount_nxt = clamped - scale_min_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qr_vld_r <= 1'b0;
      am_vld_r <= 1'b0;
    end else begin
      qr_vld_r <= q_vld[W];
      am_vld_r <= qr_vld_r;
    end
    qres_r   <= qres_nxt;
    amount_r <= amount_nxt;
  end

  // fraction amount/span as Q1.30, one quotient bit per cell
  logic          f_vld  [QW+1];
  logic [W-1:0]  f_rem  [QW+1];
  logic [QW-1:0] f_word [QW+1];

  assign f_vld[0]  = am_vld_r;
  assign f_rem[0]  = {1'b0, amount_r[W-1:1]};
  assign f_word[0] = {amount_r[0], {(QW-1){1'b0}}};

  for (genvar k = 0; k < QW; k++) begin : g_fcell
    gne_div_cell #(.RW(W), .WW(QW)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .vld_i(f_vld[k]), .rem_i(f_rem[k]), .word_i(f_word[k]), .den_i(span),
      .vld_o(f_vld[k+1]), .rem_o(f_rem[k+1]), .word_o(f_word[k+1])
    );
  end

  // angle offset: trunc(frac * pi/2) - pi/4
  logic          mv_r, pv_r;
  logic [QW-1:0] frac;
  logic [2*QW-1:0] prod;
  logic [QW-1:0] ang_r;
  logic signed [CW-1:0] phi_r;

  assign frac = span_pos ? f_word[QW] : '0;
  assign prod = frac * gne_pkg::HALF_PI_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      mv_r <= f_vld[QW];
      pv_r <= mv_r;
    end
    ang_r <= prod[gne_pkg::FRAC_BITS +: QW];
    phi_r <= {{(CW-QW){1'b0}}, ang_r} - gne_pkg::QUARTER_PI_Q30;
  end

  // CORDIC row
  logic                 c_vld [TRIG_STAGES+1];
  logic signed [CW-1:0] c_x   [TRIG_STAGES+1];
  logic signed [CW-1:0] c_y   [TRIG_STAGES+1];
  logic signed [CW-1:0] c_z   [TRIG_STAGES+1];

  assign c_vld[0] = pv_r;
  assign c_x[0]   = gne_pkg::INV_GAIN_Q30;
  assign c_y[0]   = '0;
  assign c_z[0]   = phi_r;

  for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_ccell
    gne_cordic_cell #(.IDX(k)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .vld_i(c_vld[k]), .x_i(c_x[k]), .y_i(c_y[k]), .z_i(c_z[k]),
      .vld_o(c_vld[k+1]), .x_o(c_x[k+1]), .y_o(c_y[k+1]), .z_o(c_z[k+1])
    );
  end

  // pixel offsets truncated toward zero
  logic signed [CW-1:0] fx, fy;
  logic [CW-1:0]        xmag, ymag;
  logic signed [PW-1:0] x7, y7, x5, y5;
  logic signed [PW-1:0] tip_x, tip_y, tail_x, tail_y;

  always_comb begin
    fx   = c_x[TRIG_STAGES];
    fy   = c_y[TRIG_STAGES];
    xmag = fx[CW-1] ? (~fx + 1'b1) : fx;
    ymag = fy[CW-1] ? (~fy + 1'b1) : fy;
    x7   = {3'b000, xmag[23 +: 9]};
    y7   = {3'b000, ymag[23 +: 9]};
    x5   = {3'b000, xmag[25 +: 9]};
    y5   = {3'b000, ymag[25 +: 9]};
    if (fx[CW-1]) begin
      x7 = -x7;
      x5 = -x5;
    end
    if (fy[CW-1]) begin
      y7 = -y7;
      y5 = -y5;
    end
    tip_x  = gne_pkg::PIVOT_X + y7;
    tip_y  = gne_pkg::PIVOT_Y - x7;
    tail_x = gne_pkg::PIVOT_X - y5;
    tail_y = gne_pkg::PIVOT_Y + x5;
  end

  logic       out_valid_r;
  logic [7:0] tip_x_r, tip_y_r, tail_x_r, tail_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c_vld[TRIG_STAGES];
    end
    tip_x_r  <= tip_x[7:0];
    tip_y_r  <= tip_y[7:0];
    tail_x_r <= tail_x[7:0];
    tail_y_r <= tail_y[7:0];
  end

  assign out_valid  = out_valid_r;
  assign out_tip_x  = tip_x_r;
  assign out_tip_y  = tip_y_r;
  assign out_tail_x = tail_x_r;
  assign out_tail_y = tail_y_r;

  // every accepted item is followed by out_valid once it has passed the whole pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("item did not emerge after pipeline latency");

  // needle angle stays within 45..135 degrees, so the tip is above the pivot
  a_tip_above: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tip_y <= 8'd110))
    else $error("tip outside the upper arc");

  a_tail_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tail_y >= 8'd215))
    else $error("tail outside the lower arc");

endmodule

[tb/gne_checker.sv]
// Checker for the gauge needle block: tracks registers, predicts endpoints, compares results.
module gne_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [gne_pkg::VALUE_WIDTH-1:0] in_reading,
  input  logic                            out_valid,
  input  logic [7:0]                      out_tip_x,
  input  logic [7:0]                      out_tip_y,
  input  logic [7:0]                      out_tail_x,
  input  logic [7:0]                      out_tail_y,
  input  logic                            cfg_we,
  input  logic [gne_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gne_pkg::VALUE_WIDTH-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] tip_x;
    logic [7:0] tip_y;
    logic [7:0] tail_x;
    logic [7:0] tail_y;
  } needle_t;

  longint face_min, face_max, step_size;
  needle_t endpoints_due[$];

  function automatic longint widen(logic [gne_pkg::VALUE_WIDTH-1:0] raw);
    logic signed [gne_pkg::VALUE_WIDTH-1:0] s;
    s = raw;
    return longint'(s);
  endfunction

  function automatic needle_t needle_of(logic [gne_pkg::VALUE_WIDTH-1:0] raw);
    longint v, phi, x, y, z, dx, dy, mag;
    longint unsigned span, amount, r, q, frac;
    longint tx, ty, kx, ky;
    needle_t n;
    v = widen(raw);
    if (step_size > 0) v = (v / step_size) * step_size;
    if (v < face_min) v = face_min;
    if (v > face_max) v = face_max;
    frac = 0;
    if (face_max > face_min) begin
      span = face_max - face_min;
      amount = v - face_min;
      r = amount;
      q = 0;
      if (r >= span) begin
        r = r - span;
        q = 1;
      end
      for (int i = 0; i < gne_pkg::FRAC_BITS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= span) begin
          r = r - span;
          q = q | 1;
        end
      end
      frac = q;
    end
    phi = longint'((frac * longint'(gne_pkg::HALF_PI_Q30)) >> gne_pkg::FRAC_BITS)
          - longint'(gne_pkg::QUARTER_PI_Q30);
    x = longint'(gne_pkg::INV_GAIN_Q30);
    y = 0;
    z = phi;
    for (int i = 0; i < gne_pkg::TRIG_STAGES && i < gne_pkg::ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(gne_pkg::ATAN_Q30[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(gne_pkg::ATAN_Q30[i]);
      end
    end
    // truncate toward zero: shift the magnitude, then restore the sign
    mag = (y < 0) ? -y : y;
    ty = (y < 0) ? -(mag >> 23) : (mag >> 23);
    ky = (y < 0) ? -(mag >> 25) : (mag >> 25);
    mag = (x < 0) ? -x : x;
    tx = (x < 0) ? -(mag >> 23) : (mag >> 23);
    kx = (x < 0) ? -(mag >> 25) : (mag >> 25);
    n.tip_x  = 8'(120 + ty);
    n.tip_y  = 8'(195 - tx);
    n.tail_x = 8'(120 - ky);
    n.tail_y = 8'(195 + kx);
    return n;
  endfunction

  assign pending = endpoints_due.size();

  always @(posedge clk) begin
    needle_t got, want;
    if (!rst_n) begin
      face_min  <= 0;
      face_max  <= 6553600;
      step_size <= 0;
      endpoints_due.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gne_pkg::REG_SCALE_MIN:  face_min  <= widen(cfg_wdata);
          gne_pkg::REG_SCALE_MAX:  face_max  <= widen(cfg_wdata);
          gne_pkg::REG_QUANT_STEP: step_size <= widen(cfg_wdata);
          default: ;
        endcase
      end
      if (start && !busy) endpoints_due.push_back(needle_of(in_reading));
      if (out_valid) begin
        got = '{out_tip_x, out_tip_y, out_tail_x, out_tail_y};
        if (endpoints_due.size() == 0) begin
          $display("%0t: result with none due: got %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = endpoints_due.pop_front();
          if (got !== want) begin
            $display({"%0t: endpoints mismatch: expected tip(%0d,%0d) tail(%0d,%0d),",
                      " got tip(%0d,%0d) tail(%0d,%0d)"},
                     $time, want.tip_x, want.tip_y, want.tail_x, want.tail_y,
                     got.tip_x, got.tip_y, got.tail_x, got.tail_y);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[tb/tb_top.sv]
// Top of the gauge needle testbench: clock, reset, readings, register writes and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [gne_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int LATENCY = gne_pkg::VALUE_WIDTH + gne_pkg::TRIG_STAGES + 36;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst_n, start, busy, out_valid, cfg_we;
  logic [gne_pkg::VALUE_WIDTH-1:0] in_reading, cfg_wdata;
  logic [gne_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0] out_tip_x, out_tip_y, out_tail_x, out_tail_y;
  int fail_count, pending;
  int cycles = 0;
  logic calm;
  logic signed [31:0] lo, hi;

  gauge_needle_endpoints u_dut (
    .clk, .rst_n, .start, .busy, .in_reading, .out_valid,
    .out_tip_x, .out_tip_y, .out_tail_x, .out_tail_y,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  gne_checker u_chk (
    .clk, .rst_n, .start, .busy, .in_reading, .out_valid,
    .out_tip_x, .out_tip_y, .out_tail_x, .out_tail_y,
    .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // called at a falling edge; returns at a falling edge after acceptance, after random idle gaps unless calm
  task automatic send_reading(logic [gne_pkg::VALUE_WIDTH-1:0] v);
    start <= 1'b1;
    in_reading <= v;
    @(negedge clk);
    while (busy) @(negedge clk);
    while (!calm && $urandom_range(99) < 37) begin
      start <= 1'b0;
      in_reading <= $urandom;
      @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [gne_pkg::CFG_IDX_W-1:0] idx,
                           logic [gne_pkg::VALUE_WIDTH-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_face(logic [31:0] mn, logic [31:0] mx, logic [31:0] st);
    write_reg(gne_pkg::REG_SCALE_MIN, mn);
    write_reg(gne_pkg::REG_SCALE_MAX, mx);
    write_reg(gne_pkg::REG_QUANT_STEP, st);
    @(negedge clk);
  endtask

  task automatic random_readings(int count);
    logic signed [31:0] span;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 2) && (i < count / 2 + 40);
      span = hi - lo;
      case ($urandom_range(9))
        0, 1: send_reading($urandom);
        2:    send_reading(hi + $urandom_range(3) - 1);
        3:    send_reading(lo + $urandom_range(3) - 1);
        default: send_reading((hi > lo && span > 0) ? lo + $urandom_range(span) : $urandom);
      endcase
    end
    calm = 0;
  endtask

  initial begin
    calm = 0;
    rst_n = 0;
    start = 0;
    in_reading = '0;
    cfg_we = 0;
    cfg_index = gne_pkg::REG_SCALE_MIN;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // reset face, directed extremes
    lo = 0;
    hi = 6553600;
    send_reading(32'h8000_0000);
    send_reading(32'h7FFF_FFFF);
    send_reading(32'h0);
    send_reading(32'hFFFF_FFFF);
    send_reading(32'd1);
    send_reading(32'd6553600);
    send_reading(32'd6553601);
    send_reading(32'd3276800);
    drain();

    // full-range face with unit step; spare index must be ignored
    set_face(32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
    write_reg(REG_SPARE, 32'h1234_5678);
    send_reading(32'h8000_0000);
    send_reading(32'h7FFF_FFFF);
    send_reading(32'h0);
    send_reading(32'hC000_0000);
    drain();

    // largest step, then negative step
    set_face(32'hFFF0_0000, 32'h0010_0000, 32'h7FFF_FFFF);
    send_reading(32'h7FFF_FFFF);
    send_reading(32'h8000_0000);
    send_reading(32'h0008_0000);
    drain();
    set_face(32'hFFF0_0000, 32'h0010_0000, 32'h8000_0000);
    send_reading(32'h0008_0000);
    send_reading(32'hFFF8_0000);
    drain();

    // empty and inverted faces
    set_face(32'd65536, 32'd65536, 32'd0);
    send_reading(32'd65536);
    send_reading(32'h7FFF_FFFF);
    drain();
    set_face(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    send_reading(32'h0);
    send_reading(32'h8000_0000);
    drain();

    // full-range and reset faces, then random faces
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
        1: begin lo = 0; hi = 6553600; end
        default: begin
          lo = $urandom;
          hi = $urandom;
          if (p % 3 != 0 && lo > hi) begin
            lo = lo ^ hi; hi = lo ^ hi; lo = lo ^ hi;
          end
          if (p == 4) begin
            lo = -$urandom_range(1 << 20);
            hi = $urandom_range(1 << 20);
          end
        end
      endcase
      set_face(lo, hi, (p % 2) ? $urandom_range(1 << 18) :
                        (p == 6 ? $urandom : 32'd0));
      random_readings(250);
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
